/* src/srvrx_pkg.sv */
`timescale 1ns / 1ps

package srvrx_pkg;

  // Byte that marks both header positions.
  localparam logic [7:0]  HeaderByte  = 8'h21;
  // Servo value that means "leave this servo where it is".
  localparam logic [7:0]  SkipValue   = 8'hFF;
  // Robot id after reset.
  localparam logic [15:0] RobotIdRst  = 16'd24;

  // Receive phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_HDR2  = 7'b0000010,
    PH_IDLO  = 7'b0000100,
    PH_IDHI  = 7'b0001000,
    PH_LEFT  = 7'b0010000,
    PH_RIGHT = 7'b0100000,
    PH_GRIP  = 7'b1000000
  } phase_e;

  // Raw contents of a completed frame.
  typedef struct packed {
    logic [7:0]  id_lo;
    logic [7:0]  id_hi;
    logic [7:0]  left;
    logic [7:0]  right;
    logic [7:0]  grip;
    logic [15:0] count;
  } frame_t;

  // One decoded result item.
  typedef struct packed {
    logic        id_match;
    logic [15:0] frame_id;
    logic        left_valid;
    logic [11:0] left_angle;
    logic        right_valid;
    logic [11:0] right_angle;
    logic        grip_valid;
    logic [11:0] grip_angle;
    logic [15:0] frame_count;
  } result_t;

  // Value times ten as shift-and-add; fits 12 bits for every 8-bit value.
  function automatic logic [11:0] times_ten(input logic [7:0] v);
    logic [11:0] w;
    begin
      w = {4'd0, v};
      times_ten = (w << 3) + (w << 1);
    end
  endfunction

endpackage

/* src/srvrx_parser.sv */
`timescale 1ns / 1ps

module srvrx_parser import srvrx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       done_o,
  output frame_t     frame_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  id_lo_q, id_hi_q, left_q, right_q;
  logic [15:0] count_q;
  logic        is_hdr;

  assign is_hdr = (byte_i == HeaderByte);

  // The byte in hand completes a frame when the gripper value is expected.
  assign done_o = (phase_q == PH_GRIP);

  // Next phase for the byte in hand.
  always_comb begin
    unique case (phase_q)
      PH_HUNT:  phase_d = is_hdr ? PH_HDR2 : PH_HUNT;
      PH_HDR2:  phase_d = is_hdr ? PH_IDLO : PH_HUNT;
      PH_IDLO:  phase_d = PH_IDHI;
      PH_IDHI:  phase_d = PH_LEFT;
      PH_LEFT:  phase_d = PH_RIGHT;
      PH_RIGHT: phase_d = PH_GRIP;
      PH_GRIP:  phase_d = PH_HUNT;
      default:  phase_d = is_hdr ? PH_HDR2 : PH_HUNT;
    endcase
  end

  // Phase register and frame counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      if (done_o) begin
        count_q <= count_q + 16'd1;
      end
    end
  end

  // Data byte capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_lo_q <= '0;
      id_hi_q <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else if (step_i) begin
      if (phase_q == PH_IDLO) id_lo_q <= byte_i;
      if (phase_q == PH_IDHI) id_hi_q <= byte_i;
      if (phase_q == PH_LEFT) left_q  <= byte_i;
      if (phase_q == PH_RIGHT) right_q <= byte_i;
    end
  end

  // The gripper value is the byte in hand; the count includes this frame.
  always_comb begin
    frame_o.id_lo = id_lo_q;
    frame_o.id_hi = id_hi_q;
    frame_o.left  = left_q;
    frame_o.right = right_q;
    frame_o.grip  = byte_i;
    frame_o.count = count_q + 16'd1;
  end

endmodule

/* src/srvrx_decode.sv */
`timescale 1ns / 1ps

module srvrx_decode import srvrx_pkg::*; (
  input  frame_t      frame_i,
  input  logic [15:0] robot_id_i,
  output result_t     result_o
);

  logic [15:0] fid;
  logic        match;
  logic        lv, rv, gv;

  assign fid   = {frame_i.id_hi, frame_i.id_lo};
  assign match = (fid == robot_id_i);
  assign lv    = match && (frame_i.left  != SkipValue);
  assign rv    = match && (frame_i.right != SkipValue);
  assign gv    = match && (frame_i.grip  != SkipValue);

  // Angles are zero for any servo that does not move.
  always_comb begin
    result_o.id_match    = match;
    result_o.frame_id    = fid;
    result_o.left_valid  = lv;
    result_o.left_angle  = lv ? times_ten(frame_i.left) : 12'd0;
    result_o.right_valid = rv;
    result_o.right_angle = rv ? times_ten(frame_i.right) : 12'd0;
    result_o.grip_valid  = gv;
    result_o.grip_angle  = gv ? times_ten(frame_i.grip) : 12'd0;
    result_o.frame_count = frame_i.count;
  end

endmodule

/* src/servo_command_packet_receiver_core.sv */
`timescale 1ns / 1ps
// A byte is registered on acceptance and, if it completes a frame, its result
// passes from the input register to the result register when the latter is free.
// Throughput: one byte per cycle; only the result register stalls the input.
// Reset (rst_ni, asynchronous, active low) clears both pipeline registers,
// returns to header hunting, zeroes the frame counter and sets robot id to 24.
module servo_command_packet_receiver_core import srvrx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        id_match_o,
  output logic [15:0] frame_id_o,
  output logic        left_valid_o,
  output logic [11:0] left_angle_o,
  output logic        right_valid_o,
  output logic [11:0] right_angle_o,
  output logic        grip_valid_o,
  output logic [11:0] grip_angle_o,
  output logic [15:0] frame_count_o
);

  logic [15:0] robot_id_q;
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        done;
  logic        out_free;
  logic        adv;
  frame_t      frame;
  result_t     result;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_id_q <= RobotIdRst;
    end else if (cfg_we_i) begin
      robot_id_q <= cfg_wdata_i;
    end
  end

  // A registered byte moves on unless it completes a frame and the result
  // register is still occupied.
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && (!done || out_free);
  assign in_ready_o = !in_valid_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      byte_q     <= '0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
      byte_q     <= rx_byte_i;
    end
  end

  srvrx_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .byte_i  (byte_q),
    .done_o  (done),
    .frame_o (frame)
  );

  srvrx_decode u_decode (
    .frame_i    (frame),
    .robot_id_i (robot_id_q),
    .result_o   (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (out_free) begin
      out_valid_q <= adv && done;
      out_q       <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign id_match_o    = out_q.id_match;
  assign frame_id_o    = out_q.frame_id;
  assign left_valid_o  = out_q.left_valid;
  assign left_angle_o  = out_q.left_angle;
  assign right_valid_o = out_q.right_valid;
  assign right_angle_o = out_q.right_angle;
  assign grip_valid_o  = out_q.grip_valid;
  assign grip_angle_o  = out_q.grip_angle;
  assign frame_count_o = out_q.frame_count;

endmodule

/* sim/tb_servo_command_packet_receiver_core.sv */
`timescale 1ns / 1ps

module tb_servo_command_packet_receiver_core import srvrx_pkg::*; ();

  localparam int AngleScale = 10;
  localparam int MaxGap     = 14;
  localparam int DrainWait  = 4;
  localparam int CycleLimit = 2_000_000;
  // Cap on printed mismatches so a badly broken block cannot flood the log.
  localparam int ReportCap  = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        id_match_o;
  logic [15:0] frame_id_o;
  logic        left_valid_o;
  logic [11:0] left_angle_o;
  logic        right_valid_o;
  logic [11:0] right_angle_o;
  logic        grip_valid_o;
  logic [11:0] grip_angle_o;
  logic [15:0] frame_count_o;

  servo_command_packet_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .id_match_o    (id_match_o),
    .frame_id_o    (frame_id_o),
    .left_valid_o  (left_valid_o),
    .left_angle_o  (left_angle_o),
    .right_valid_o (right_valid_o),
    .right_angle_o (right_angle_o),
    .grip_valid_o  (grip_valid_o),
    .grip_angle_o  (grip_angle_o),
    .frame_count_o (frame_count_o)
  );

  // Clock and run-time limit.
  always #5 clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Decoder state mirrored by the testbench.
  phase_e      rx_phase = PH_HUNT;
  logic [7:0]  id_lo = '0;
  logic [7:0]  id_hi = '0;
  logic [7:0]  left_val = '0;
  logic [7:0]  right_val = '0;
  logic [15:0] frames_done = '0;
  logic [15:0] accepted_id = RobotIdRst;

  result_t expected_frames[$];
  int      error_count = 0;
  bit      sender_burst = 1'b0;
  bit      receiver_burst = 1'b0;

  // One servo channel: valid only on an id match and a value other than skip.
  function automatic void servo_cmd(input logic match, input logic [7:0] v,
                                    output logic ok, output logic [11:0] angle);
    ok = match && (v != SkipValue);
    angle = ok ? 12'(int'(v) * AngleScale) : 12'd0;
  endfunction

  // Advance the mirrored decoder by one received byte; a completed frame
  // queues its expected result.
  function automatic void decode_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] id;
    case (rx_phase)
      PH_HDR2: rx_phase = (b == HeaderByte) ? PH_IDLO : PH_HUNT;
      PH_IDLO: begin
        id_lo = b;
        rx_phase = PH_IDHI;
      end
      PH_IDHI: begin
        id_hi = b;
        rx_phase = PH_LEFT;
      end
      PH_LEFT: begin
        left_val = b;
        rx_phase = PH_RIGHT;
      end
      PH_RIGHT: begin
        right_val = b;
        rx_phase = PH_GRIP;
      end
      PH_GRIP: begin
        rx_phase = PH_HUNT;
        frames_done = frames_done + 16'd1;
        id = {id_hi, id_lo};
        r.id_match = (id == accepted_id);
        r.frame_id = id;
        servo_cmd(r.id_match, left_val, r.left_valid, r.left_angle);
        servo_cmd(r.id_match, right_val, r.right_valid, r.right_angle);
        servo_cmd(r.id_match, b, r.grip_valid, r.grip_angle);
        r.frame_count = frames_done;
        expected_frames.push_back(r);
      end
      default: rx_phase = (b == HeaderByte) ? PH_HDR2 : PH_HUNT;
    endcase
  endfunction

  // Send one byte after a random gap (none in sender burst mode) and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [7:0] l,
                            input logic [7:0] r, input logic [7:0] g);
    send_byte(HeaderByte);
    send_byte(HeaderByte);
    send_byte(id[7:0]);
    send_byte(id[15:8]);
    send_byte(l);
    send_byte(r);
    send_byte(g);
  endtask

  // Hold off the sender until every result is out and the pipeline is empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_robot_id(input logic [15:0] id);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    accepted_id = id;
  endtask

  function automatic logic [7:0] servo_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return SkipValue;
    if (pick == 2) return 8'd0;
    if (pick == 3) return 8'd254;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 3) == 0) return HeaderByte;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] non_header_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == HeaderByte);
    return b;
  endfunction

  // Frame id that matches half the time and otherwise misses, often by one bit.
  function automatic logic [15:0] frame_id_pick();
    case ($urandom_range(0, 3))
      0, 1: return accepted_id;
      2: return accepted_id ^ (16'd1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= ReportCap)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Result side: random stall before each item (none in receiver burst mode), then
  // compare it with the oldest expected frame.
  initial begin
    int      stall;
    result_t want;
    wait (rst_ni);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_frames.size() == 0) begin
        error_count++;
        if (error_count <= ReportCap)
          $error("result item with no frame expected, frame_count %0d", frame_count_o);
      end else begin
        want = expected_frames.pop_front();
        check_field("id_match", 16'(want.id_match), 16'(id_match_o));
        check_field("frame_id", want.frame_id, frame_id_o);
        check_field("left_valid", 16'(want.left_valid), 16'(left_valid_o));
        check_field("left_angle", 16'(want.left_angle), 16'(left_angle_o));
        check_field("right_valid", 16'(want.right_valid), 16'(right_valid_o));
        check_field("right_angle", 16'(want.right_angle), 16'(right_angle_o));
        check_field("grip_valid", 16'(want.grip_valid), 16'(grip_valid_o));
        check_field("grip_angle", 16'(want.grip_angle), 16'(grip_angle_o));
        check_field("frame_count", want.frame_count, frame_count_o);
      end
    end
  end

  // Robot id after reset; servo values at zero, skip and the top of range.
  task automatic test_default_id();
    send_frame(RobotIdRst, 8'd0, SkipValue, 8'd254);
  endtask

  // All-ones robot id, with a header byte carried as a servo value.
  task automatic test_id_extremes();
    write_robot_id(16'hFFFF);
    send_frame(16'hFFFF, HeaderByte, 8'd1, 8'd128);
    write_robot_id(16'h0000);
  endtask

  // A broken header is dropped; the next frame has an id that misses.
  task automatic test_header_resync();
    send_byte(HeaderByte);
    send_byte(8'h41);
    send_frame(16'h8001, SkipValue, 8'd0, HeaderByte);
  endtask

  // Mostly well-formed frames with random content, mixed with noise,
  // broken headers, id changes and pauses.
  task automatic test_random_traffic();
    int sent;
    int pick;
    sent = 0;
    while (sent < 550) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(frame_id_pick(), servo_value(), servo_value(), servo_value());
        sent += 7;
      end else if (pick < 78) begin
        send_byte(HeaderByte);
        send_byte(non_header_byte());
        sent += 2;
      end else if (pick < 88) begin
        send_byte(noise_byte());
        sent += 1;
      end else if (pick < 94) begin
        sender_burst   = ($urandom_range(0, 2) == 0);
        receiver_burst = ($urandom_range(0, 2) == 0);
      end else if (pick < 97) begin
        drain_results();
      end else begin
        case ($urandom_range(0, 3))
          0: write_robot_id(16'h0000);
          1: write_robot_id(16'hFFFF);
          default: write_robot_id(16'($urandom));
        endcase
      end
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_id();
    test_id_extremes();
    test_header_resync();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
